[design/tspe_pkg.sv]
package tspe_pkg;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_KNOT  = 2'd1,
    KIND_EVAL  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CURVE_LINEAR  = 2'd0,
    CURVE_CATMULL = 2'd1,
    CURVE_BEZIER  = 2'd2,
    CURVE_RSVD    = 2'd3
  } curve_e;

  localparam logic [1:0] REG_CURVE_MODE  = 2'd0;
  localparam logic [1:0] REG_WRAP_MODE   = 2'd1;
  localparam logic [1:0] REG_FIRST_INDEX = 2'd2;
  localparam logic [1:0] REG_LAST_INDEX  = 2'd3;

  // Table indexes wrap at the address width, so the depth stays a power of two.
  localparam int unsigned TableDepth = 64;

  localparam int unsigned TimeW = 32;
  localparam int unsigned FracW = 17;
  localparam int unsigned WeightW = 50;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_BOUNDS,
    ST_LATCH_LOW,
    ST_LATCH_HIGH,
    ST_RANGE,
    ST_WRAP_DIV,
    ST_SEARCH_RD,
    ST_SEARCH_CHK,
    ST_SEG_RD,
    ST_SEG_A,
    ST_SEG_B,
    ST_FRAC_DIV,
    ST_BASIS1,
    ST_BASIS2,
    ST_BASIS3,
    ST_PT_RD,
    ST_PT_MUL,
    ST_PT_ACC,
    ST_FINISH,
    ST_OUT
  } state_e;

  // Restoring divider request/response.
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

[design/timed_spline_point_evaluator_unit.sv]
// Timed spline point evaluator. Items of kind point or knot write one entry of the point
// or knot memory and give no result. An evaluate item reads the knot range, wraps the
// time with a division or clamps it; unless it clamps, it then walks the knot memory
// linearly from first_index and forms the fraction with a division on the same serial
// divider when the time lies strictly between two knots. It then builds the basis
// weights and blends four control points, each point one memory read and a
// multiply-accumulate per coordinate. The block takes one item at a time.
module timed_spline_point_evaluator_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry[5:0], coord_x[37:6], coord_y[69:38], coord_z[101:70], time_ms[133:102]
  input  logic [135:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], segment[101:96], time_used[133:102]
  output logic [135:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [5:0]   cfg_data_i
);
  import tspe_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned PW = 3 * COORD_WIDTH;

  // configuration
  logic [1:0] curve_mode_q;
  logic       wrap_mode_q;
  logic [5:0] first_index_q, last_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_mode_q  <= '0;
      wrap_mode_q   <= 1'b0;
      first_index_q <= '0;
      last_index_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CURVE_MODE:  curve_mode_q  <= cfg_data_i[1:0];
        REG_WRAP_MODE:   wrap_mode_q   <= cfg_data_i[0];
        REG_FIRST_INDEX: first_index_q <= cfg_data_i;
        REG_LAST_INDEX:  last_index_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input fields
  logic [1:0]  in_kind;
  logic [5:0]  in_entry;
  logic [31:0] in_x, in_y, in_z, in_time;
  assign in_kind  = s_axis_tuser;
  assign in_entry = s_axis_tdata[5:0];
  assign in_x     = s_axis_tdata[37:6];
  assign in_y     = s_axis_tdata[69:38];
  assign in_z     = s_axis_tdata[101:70];
  assign in_time  = s_axis_tdata[133:102];

  state_e state_q, state_d;
  logic   accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  // memories
  logic          pt_we, kn_we;
  logic [AW-1:0] wr_addr, kn_raddr_d, pt_raddr_d;
  logic [PW-1:0] pt_wdata, pt_rdata;
  logic [31:0]   kn_rdata;

  assign wr_addr  = AW'(in_entry);
  assign pt_we    = accept && (in_kind == KIND_POINT);
  assign kn_we    = accept && (in_kind == KIND_KNOT);
  // Each coordinate is kept at COORD_WIDTH bits with its sign carried along.
  assign pt_wdata = {COORD_WIDTH'($signed(in_z)), COORD_WIDTH'($signed(in_y)),
                     COORD_WIDTH'($signed(in_x))};

  tspe_ram #(.Width(PW), .Depth(TableDepth)) u_pt_ram (
    .clk_i, .we_i(pt_we), .waddr_i(wr_addr), .wdata_i(pt_wdata),
    .raddr_i(pt_raddr_d), .rdata_o(pt_rdata)
  );
  tspe_ram #(.Width(32), .Depth(TableDepth)) u_kn_ram (
    .clk_i, .we_i(kn_we), .waddr_i(wr_addr), .wdata_i(in_time),
    .raddr_i(kn_raddr_d), .rdata_o(kn_rdata)
  );

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;
  tspe_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // datapath registers
  logic [31:0] t_q, t_d, low_q, low_d, high_q, high_d, a_q, a_d;
  logic [AW-1:0] seg_q, seg_d;
  logic [16:0] frac_q, frac_d;
  logic signed [WeightW-1:0] w_q [4];
  logic signed [WeightW-1:0] w_d [4];
  logic signed [50:0] t1_q, t1_d, t2_q, t2_d, t3_q, t3_d;
  logic [1:0] mode_q, mode_d, k_q, k_d;
  logic [1:0] c_q, c_d;
  logic signed [63:0] sh_q [3];
  logic signed [63:0] sh_d [3];
  logic signed [63:0] sl_q [3];
  logic signed [63:0] sl_d [3];
  logic signed [COORD_WIDTH-1:0] p_q, p_d;
  logic signed [PW-1:0] pts_q, pts_d;
  logic [135:0] out_q, out_d;

  function automatic logic signed [63:0] fshr(input logic signed [63:0] v,
                                              input int unsigned s);
    fshr = v >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'h7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'h80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  logic [AW-1:0] lo_i, hi_i, seg_nxt;
  logic [AW:0]   seg_p1_wide;
  logic [AW-1:0] idx_k;
  logic [AW+1:0] seg3;
  logic signed [63:0] ph, pl, prod_h, prod_l, rr;
  logic signed [WeightW-1:0] wk;
  logic signed [64:0] one48;

  assign lo_i = AW'(first_index_q);
  assign hi_i = AW'(last_index_q);
  assign seg_nxt = seg_q + AW'(1);
  assign seg_p1_wide = {1'b0, seg_q} + (AW+1)'(1);
  assign seg3 = (AW+2)'(seg_q) * (AW+2)'(3);
  assign one48 = 65'sd1 <<< 48;

  always_comb begin
    case (mode_q)
      CURVE_CATMULL: idx_k = seg_q + AW'(k_q) - AW'(1);
      CURVE_BEZIER:  idx_k = AW'(seg3) + AW'(k_q);
      default:       idx_k = (k_q == 2'd0) ? seg_q : seg_nxt;
    endcase
  end

  always_comb begin
    wk = w_q[k_q];
    ph = fshr(64'(p_q), 24);
    pl = 64'(p_q) - (ph <<< 24);
    prod_h = ph * 64'(wk);
    prod_l = pl * 64'(wk);
  end

  always_comb begin
    state_d = state_q;
    t_d = t_q; low_d = low_q; high_d = high_q; a_d = a_q; seg_d = seg_q;
    frac_d = frac_q; t1_d = t1_q; t2_d = t2_q; t3_d = t3_q;
    mode_d = mode_q; k_d = k_q; c_d = c_q; p_d = p_q; pts_d = pts_q; out_d = out_q;
    for (int i = 0; i < 4; i++) w_d[i] = w_q[i];
    for (int i = 0; i < 3; i++) begin
      sh_d[i] = sh_q[i];
      sl_d[i] = sl_q[i];
    end
    kn_raddr_d = lo_i;
    pt_raddr_d = idx_k;
    div_req = '0;
    rr = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_kind == KIND_EVAL) begin
          t_d = in_time;
          state_d = ST_RD_BOUNDS;
        end
      end
      ST_RD_BOUNDS: begin
        kn_raddr_d = lo_i;
        state_d = ST_LATCH_LOW;
      end
      ST_LATCH_LOW: begin
        kn_raddr_d = hi_i;
        low_d = kn_rdata;
        state_d = ST_LATCH_HIGH;
      end
      ST_LATCH_HIGH: begin
        high_d = kn_rdata;
        state_d = ST_RANGE;
      end
      ST_RANGE: begin
        seg_d = lo_i;
        frac_d = '0;
        if (t_q < low_q || t_q >= high_q) begin
          if (wrap_mode_q && high_q > low_q) begin
            // t below low only needs the mod of a negative offset; fold it by sign.
            div_req.start = 1'b1;
            div_req.num = (t_q >= low_q) ? 48'(t_q - low_q) : 48'(low_q - t_q);
            div_req.den = high_q - low_q;
            state_d = ST_WRAP_DIV;
          end else begin
            if (t_q < low_q) begin
              t_d = low_q;
            end else begin
              seg_d = hi_i;
              t_d = high_q;
            end
            state_d = ST_BASIS1;
          end
        end else begin
          state_d = ST_SEARCH_RD;
        end
      end
      ST_WRAP_DIV: begin
        if (div_rsp.done) begin
          if (t_q >= low_q || div_rsp.rem == '0) begin
            t_d = low_q + div_rsp.rem;
          end else begin
            t_d = low_q + (high_q - low_q) - div_rsp.rem;
          end
          state_d = ST_SEARCH_RD;
        end
      end
      ST_SEARCH_RD: begin
        kn_raddr_d = seg_nxt;
        if (32'(seg_p1_wide) < 32'(hi_i)) begin
          state_d = ST_SEARCH_CHK;
        end else begin
          state_d = ST_SEG_RD;
        end
      end
      ST_SEARCH_CHK: begin
        if (kn_rdata < t_q) begin
          seg_d = seg_nxt;
          state_d = ST_SEARCH_RD;
        end else begin
          state_d = ST_SEG_RD;
        end
      end
      ST_SEG_RD: begin
        kn_raddr_d = seg_q;
        state_d = ST_SEG_A;
      end
      ST_SEG_A: begin
        kn_raddr_d = seg_nxt;
        a_d = kn_rdata;
        state_d = ST_SEG_B;
      end
      ST_SEG_B: begin
        if (t_q <= a_q) begin
          frac_d = '0;
          state_d = ST_BASIS1;
        end else if (kn_rdata <= t_q) begin
          frac_d = 17'h10000;
          state_d = ST_BASIS1;
        end else begin
          div_req.start = 1'b1;
          div_req.num = {t_q - a_q, 16'h0};
          div_req.den = kn_rdata - a_q;
          state_d = ST_FRAC_DIV;
        end
      end
      ST_FRAC_DIV: begin
        if (div_rsp.done) begin
          frac_d = div_rsp.quot[16:0];
          state_d = ST_BASIS1;
        end
      end
      ST_BASIS1: begin
        mode_d = (curve_mode_q == CURVE_CATMULL || curve_mode_q == CURVE_BEZIER)
                 ? curve_mode_q : CURVE_LINEAR;
        t1_d = 51'(frac_q) <<< 32;
        t2_d = 51'(34'(frac_q) * 34'(frac_q)) <<< 16;
        state_d = ST_BASIS2;
      end
      ST_BASIS2: begin
        t3_d = 51'(52'(t2_q >>> 16) * 52'(frac_q));
        state_d = ST_BASIS3;
      end
      ST_BASIS3: begin
        case (mode_q)
          CURVE_CATMULL: begin
            w_d[0] = WeightW'(fshr(64'(-t3_q + 2 * t2_q - t1_q), 17));
            w_d[1] = WeightW'(fshr(64'(3 * t3_q - 5 * t2_q) + 64'(2 * one48), 17));
            w_d[2] = WeightW'(fshr(64'(-3 * t3_q + 4 * t2_q + t1_q), 17));
            w_d[3] = WeightW'(fshr(64'(t3_q - t2_q), 17));
          end
          CURVE_BEZIER: begin
            w_d[0] = WeightW'(fshr(64'(-t3_q + 3 * t2_q - 3 * t1_q) + 64'(one48), 16));
            w_d[1] = WeightW'(fshr(64'(3 * t3_q - 6 * t2_q + 3 * t1_q), 16));
            w_d[2] = WeightW'(fshr(64'(-3 * t3_q + 3 * t2_q), 16));
            w_d[3] = WeightW'(fshr(64'(t3_q), 16));
          end
          default: begin
            w_d[0] = WeightW'(fshr(64'(one48) - 64'(t1_q), 16));
            w_d[1] = WeightW'(fshr(64'(t1_q), 16));
            w_d[2] = '0;
            w_d[3] = '0;
          end
        endcase
        for (int i = 0; i < 3; i++) begin
          sh_d[i] = '0;
          sl_d[i] = '0;
        end
        k_d = 2'd0;
        state_d = ST_PT_RD;
      end
      ST_PT_RD: begin
        c_d = 2'd0;
        state_d = ST_PT_MUL;
      end
      ST_PT_MUL: begin
        pts_d = pt_rdata;
        p_d = pt_rdata[COORD_WIDTH-1:0];
        state_d = ST_PT_ACC;
      end
      ST_PT_ACC: begin
        sh_d[c_q] = sh_q[c_q] + prod_h;
        sl_d[c_q] = sl_q[c_q] + prod_l;
        if (c_q == 2'd2) begin
          if (k_q == 2'd3) begin
            c_d = 2'd0;
            state_d = ST_FINISH;
          end else begin
            k_d = k_q + 2'd1;
            state_d = ST_PT_RD;
          end
        end else begin
          c_d = c_q + 2'd1;
          p_d = (c_q == 2'd0) ? pts_q[2*COORD_WIDTH-1:COORD_WIDTH]
                              : pts_q[PW-1:2*COORD_WIDTH];
        end
      end
      ST_FINISH: begin
        rr = fshr(sh_q[c_q] + fshr(sl_q[c_q], 24), 8);
        out_d[32*c_q +: 32] = sat32(rr);
        if (c_q == 2'd2) begin
          out_d[101:96] = 6'(seg_q);
          out_d[133:102] = t_q;
          out_d[135:134] = '0;
          state_d = ST_OUT;
        end else begin
          c_d = c_q + 2'd1;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d; low_q <= low_d; high_q <= high_d; a_q <= a_d; seg_q <= seg_d;
    frac_q <= frac_d; t1_q <= t1_d; t2_q <= t2_d; t3_q <= t3_d;
    mode_q <= mode_d; k_q <= k_d; c_q <= c_d; p_q <= p_d; pts_q <= pts_d;
    out_q <= out_d;
    for (int i = 0; i < 4; i++) w_q[i] <= w_d[i];
    for (int i = 0; i < 3; i++) begin
      sh_q[i] <= sh_d[i];
      sl_q[i] <= sl_d[i];
    end
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = out_q;

endmodule

[design/tspe_ram.sv]
module tspe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/tspe_div.sv]
module tspe_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  tspe_pkg::div_req_t req_i,
  output tspe_pkg::div_rsp_t rsp_o
);
  import tspe_pkg::*;

  logic [47:0] quot_q, quot_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  // One quotient bit per cycle over the 48-bit dividend.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[47]};
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = 32'(trial - {1'b0, den_q});
        quot_d = {quot_q[46:0], 1'b1};
      end else begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tspe_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 400;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [5:0]  segment;
    logic [31:0] time_used;
  } position_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;
  logic         cfg_we_i;
  logic [1:0]   cfg_index_i;
  logic [5:0]   cfg_data_i;

  timed_spline_point_evaluator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the tables and registers.
  logic signed [31:0] pts[3][Depth];
  logic [31:0]        knots[Depth];
  curve_e             curve_sel;
  logic               wrap_sel;
  logic [5:0]         first_idx;
  logic [5:0]         last_idx;

  position_t   expected_positions[$];
  int unsigned fail_count;
  int unsigned eval_count;
  int unsigned result_count;
  int unsigned cycle_count;
  bit          quiet;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99, 0) >= 22);
    end
  end

  function automatic void spline_weights(curve_e mode, int unsigned frac, output longint w[4]);
    longint t, one, t1, t2, t3;
    t = longint'(frac);
    one = longint'(1) <<< 48;
    t1 = t * (longint'(1) <<< 32);
    t2 = t * t * 65536;
    t3 = t * t * t;
    if (mode == CURVE_CATMULL) begin
      w[0] = (-t3 + 2 * t2 - t1) >>> 17;
      w[1] = (3 * t3 - 5 * t2 + 2 * one) >>> 17;
      w[2] = (-3 * t3 + 4 * t2 + t1) >>> 17;
      w[3] = (t3 - t2) >>> 17;
    end else if (mode == CURVE_BEZIER) begin
      w[0] = (-t3 + 3 * t2 - 3 * t1 + one) >>> 16;
      w[1] = (3 * t3 - 6 * t2 + 3 * t1) >>> 16;
      w[2] = (-3 * t3 + 3 * t2) >>> 16;
      w[3] = t3 >>> 16;
    end else begin
      w[0] = (one - t1) >>> 16;
      w[1] = t1 >>> 16;
      w[2] = 0;
      w[3] = 0;
    end
  endfunction

  function automatic position_t predict_position(logic [31:0] query);
    position_t res;
    logic [31:0] low, high, x, a, b;
    int unsigned seg, frac;
    int unsigned idx[4];
    longint w[4];
    longint d, dur, r;
    logic signed [127:0] acc, pv, wv, q;
    bit searched;
    curve_e mode;
    low = knots[first_idx];
    high = knots[last_idx];
    x = query;
    seg = 32'(first_idx);
    frac = 0;
    searched = 1'b1;
    if (x < low || x >= high) begin
      if (wrap_sel && high > low) begin
        d = longint'(x) - longint'(low);
        dur = longint'(high) - longint'(low);
        r = d % dur;
        if (r < 0) r += dur;
        x = 32'(longint'(low) + r);
      end else begin
        searched = 1'b0;
        if (x < low) begin
          x = low;
        end else begin
          seg = 32'(last_idx);
          x = high;
        end
      end
    end
    if (searched) begin
      seg = 32'(first_idx);
      while (seg + 1 < last_idx && knots[seg + 1] < x) seg++;
      a = knots[seg];
      b = knots[(seg + 1) % Depth];
      if (x <= a) frac = 0;
      else if (b <= x) frac = 65536;
      else frac = 32'(((64'(x - a)) << 16) / 64'(b - a));
    end
    mode = curve_sel;
    if (mode == CURVE_CATMULL) begin
      for (int k = 0; k < 4; k++) idx[k] = (seg + Depth - 1 + k) % Depth;
    end else if (mode == CURVE_BEZIER) begin
      for (int k = 0; k < 4; k++) idx[k] = (3 * seg + k) % Depth;
    end else begin
      // The reserved mode blends like linear.
      mode = CURVE_LINEAR;
      idx[0] = seg % Depth;
      for (int k = 1; k < 4; k++) idx[k] = (seg + 1) % Depth;
    end
    spline_weights(mode, frac, w);
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        pv = 128'(pts[c][idx[k]]);
        wv = 128'(w[k]);
        acc = acc + pv * wv;
      end
      q = acc >>> 32;
      if (q > 128'sd2147483647) q = 128'sd2147483647;
      if (q < -128'sd2147483648) q = -128'sd2147483648;
      case (c)
        0: res.pos_x = q[31:0];
        1: res.pos_y = q[31:0];
        default: res.pos_z = q[31:0];
      endcase
    end
    res.segment = seg[5:0];
    res.time_used = x;
    return res;
  endfunction

  // Returns at the clock edge at which the item was taken; tvalid stays high.
  task automatic send_item(kind_e kind, logic [5:0] entry, logic [31:0] cx, logic [31:0] cy,
                           logic [31:0] cz, logic [31:0] t);
    while (!quiet && $urandom_range(99, 0) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {2'b00, t, cz, cy, cx, entry};
    do @(posedge clk_i); while (!s_axis_tready);
    case (kind)
      KIND_POINT: begin
        pts[0][entry] = cx;
        pts[1][entry] = cy;
        pts[2][entry] = cz;
      end
      KIND_KNOT: knots[entry] = t;
      KIND_EVAL: begin
        expected_positions.push_back(predict_position(t));
        eval_count++;
      end
      default: ;
    endcase
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, logic [5:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      REG_CURVE_MODE: curve_sel = curve_e'(value[1:0]);
      REG_WRAP_MODE: wrap_sel = value[0];
      REG_FIRST_INDEX: first_idx = value;
      default: last_idx = value;
    endcase
  endtask

  task automatic configure(curve_e mode, logic wrap, logic [5:0] first, logic [5:0] last);
    settle();
    write_reg(REG_CURVE_MODE, 6'(mode));
    write_reg(REG_WRAP_MODE, 6'(wrap));
    write_reg(REG_FIRST_INDEX, first);
    write_reg(REG_LAST_INDEX, last);
  endtask

  task automatic send_point(logic [5:0] entry);
    send_item(KIND_POINT, entry, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Non-decreasing knot times from the given base, step bounded by max_step.
  task automatic load_knots(logic [31:0] base, int unsigned max_step);
    logic [31:0] t;
    t = base;
    for (int i = 0; i < Depth; i++) begin
      send_item(KIND_KNOT, 6'(i), $urandom, $urandom, $urandom, t);
      t = t + $urandom_range(max_step, 0);
    end
  endtask

  function automatic logic [31:0] pick_time();
    logic [31:0] low, high;
    int unsigned sel;
    low = knots[first_idx];
    high = knots[last_idx];
    sel = $urandom_range(99, 0);
    if (sel < 65 && high > low) return $urandom_range(high, low);
    if (sel < 80) return knots[$urandom_range(Depth - 1, 0)];
    if (sel < 88) return low - $urandom_range(1000, 1);
    if (sel < 94) return high + $urandom_range(1000, 0);
    return $urandom;
  endfunction

  task automatic test_load_tables();
    for (int i = 0; i < Depth; i++) send_point(6'(i));
    load_knots(32'd1000, 400);
  endtask

  task automatic test_directed();
    configure(CURVE_LINEAR, 1'b0, 6'd0, 6'd8);
    send_item(KIND_POINT, 6'd1, 32'h7fffffff, 32'h80000000, 32'h00000000, '0);
    send_item(KIND_POINT, 6'd2, 32'h80000000, 32'h7fffffff, 32'hffffffff, '0);
    send_item(KIND_EVAL, '0, '0, '0, '0, knots[0]);
    send_item(KIND_EVAL, '0, '0, '0, '0, knots[0] - 1);
    send_item(KIND_EVAL, '0, '0, '0, '0, knots[8]);
    send_item(KIND_EVAL, '0, '0, '0, '0, 32'hffffffff);
    send_item(KIND_EVAL, '0, '0, '0, '0, 32'h0);
    send_item(KIND_EVAL, '0, '0, '0, '0, knots[1] + 1);
    send_item(KIND_EVAL, '0, '0, '0, '0, knots[3]);
    // Reserved kind is dropped without a result.
    send_item(KIND_NONE, 6'd5, $urandom, $urandom, $urandom, $urandom);
    configure(CURVE_CATMULL, 1'b1, 6'd0, 6'd8);
    send_item(KIND_EVAL, '0, '0, '0, '0, knots[8] + 5);
    send_item(KIND_EVAL, '0, '0, '0, '0, 32'h0);
    send_item(KIND_EVAL, '0, '0, '0, '0, (knots[1] + knots[2]) / 2);
    configure(CURVE_BEZIER, 1'b1, 6'd0, 6'd8);
    send_item(KIND_EVAL, '0, '0, '0, '0, (knots[0] + knots[1]) / 2);
    send_item(KIND_EVAL, '0, '0, '0, '0, 32'hffffffff);
    configure(CURVE_RSVD, 1'b0, 6'd1, 6'd6);
    send_item(KIND_EVAL, '0, '0, '0, '0, knots[3] + 7);
    // Empty range: first index above last clamps even with wrap on.
    configure(CURVE_LINEAR, 1'b1, 6'd63, 6'd0);
    send_item(KIND_EVAL, '0, '0, '0, '0, 32'h12345678);
    send_item(KIND_EVAL, '0, '0, '0, '0, 32'h0);
    // Two equal knots give a zero spacing inside the range.
    send_item(KIND_KNOT, 6'd20, '0, '0, '0, knots[19]);
    configure(CURVE_CATMULL, 1'b0, 6'd18, 6'd23);
    send_item(KIND_EVAL, '0, '0, '0, '0, knots[19]);
    send_item(KIND_EVAL, '0, '0, '0, '0, knots[21] - 1);
  endtask

  task automatic test_random(int unsigned phases);
    int unsigned span, n;
    logic [5:0] first;
    for (int p = 0; p < phases; p++) begin
      if (p == 2) begin
        configure(CURVE_BEZIER, 1'b1, 6'd0, 6'd63);
      end else if (p == 3) begin
        configure(CURVE_CATMULL, 1'b0, 6'd63, 6'd63);
      end else begin
        span = ($urandom_range(9, 0) == 0) ? $urandom_range(63, 0) : $urandom_range(12, 0);
        first = 6'($urandom);
        configure(curve_e'($urandom_range(3, 0)), 1'($urandom_range(1, 0)), first,
                  first + 6'(span));
      end
      if (p == 5) load_knots($urandom, 50000);
      if (p == 6) load_knots($urandom_range(200, 0), 3);
      quiet = (p == 1);
      n = $urandom_range(50, 30);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(19, 0))
          0, 1: send_point(6'($urandom));
          2: send_item(KIND_KNOT, 6'($urandom), $urandom, $urandom, $urandom, $urandom);
          3: send_item(KIND_NONE, 6'($urandom), $urandom, $urandom, $urandom, $urandom);
          default: send_item(KIND_EVAL, 6'($urandom), $urandom, $urandom, $urandom,
                             pick_time());
        endcase
      end
      quiet = 1'b0;
    end
  endtask

  // Each evaluate waits for its result before the next goes out.
  task automatic test_one_at_a_time();
    configure(CURVE_LINEAR, 1'b1, 6'd4, 6'd14);
    for (int i = 0; i < 12; i++) begin
      send_item(KIND_EVAL, '0, '0, '0, '0, pick_time());
      settle();
    end
  endtask

  always @(posedge clk_i) begin
    position_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tdata[101:96], m_axis_tdata[133:102]};
      result_count++;
      if (expected_positions.size() == 0) begin
        $error("unexpected result item %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_positions.pop_front();
        if (got.pos_x !== want.pos_x) begin
          $error("pos_x: expected %h, got %h", want.pos_x, got.pos_x);
          fail_count++;
        end
        if (got.pos_y !== want.pos_y) begin
          $error("pos_y: expected %h, got %h", want.pos_y, got.pos_y);
          fail_count++;
        end
        if (got.pos_z !== want.pos_z) begin
          $error("pos_z: expected %h, got %h", want.pos_z, got.pos_z);
          fail_count++;
        end
        if (got.segment !== want.segment) begin
          $error("segment: expected %0d, got %0d", want.segment, got.segment);
          fail_count++;
        end
        if (got.time_used !== want.time_used) begin
          $error("time_used: expected %h, got %h", want.time_used, got.time_used);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_POINT;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_CURVE_MODE;
    cfg_data_i = '0;
    curve_sel = CURVE_LINEAR;
    wrap_sel = 1'b0;
    first_idx = '0;
    last_idx = '0;
    quiet = 1'b0;
    fail_count = 0;
    eval_count = 0;
    result_count = 0;
    cycle_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_tables();
    test_directed();
    test_one_at_a_time();
    test_random(9);
    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_positions.size() != 0) begin
      $error("%0d expected results never arrived", expected_positions.size());
      fail_count++;
    end
    $display("Covered %0d evaluations in all curve, wrap and clamp settings;", eval_count);
    $display("%0d results checked, %0d mismatches.", result_count, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
